FILE: hw/rtl/pts_pkg.sv
// ----------------------------------------------------------------------------
// Periodic task tick scheduler package
// Shared sizes, codes, the token and event types of the slot chain, and the
// division by the tick length.
// ----------------------------------------------------------------------------
package pts_pkg;

  // Table geometry and tick length.
  localparam int NUM_SLOTS   = 8;
  localparam int TICK_MS     = 10;
  localparam int MAX_RESULTS = 8;

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);

  // Division by TICK_MS as a multiplication by a rounded-up reciprocal.
  // With the shift at 16 plus the bit length of TICK_MS the quotient is
  // exact for every 16-bit dividend.
  localparam int          DIV_SHIFT = 16 + $clog2(TICK_MS);
  localparam logic [63:0] DIV_MULT  = ((64'd1 << DIV_SHIFT) + TICK_MS - 1) / TICK_MS;
  localparam int          MULT_W    = $clog2(DIV_MULT + 1);
  localparam int          PROD_W    = 16 + MULT_W;

  // Operation codes of the action field.
  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_ADD  = 2'd1,
    ACT_DEL  = 2'd2,
    ACT_DISP = 2'd3
  } act_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_DUP      = 3'd1,
    ST_FULL     = 3'd2,
    ST_BAD_ID   = 3'd3,
    ST_DELETED  = 3'd4,
    ST_NOTFOUND = 3'd5,
    ST_DONE     = 3'd6
  } status_t;

  // Token that walks the chain of slot cells, one cell per cycle while the output is not stalled.
  typedef struct packed {
    logic             vld;
    act_t             op;
    logic [7:0]       id;
    logic [15:0]      delay_q;
    logic [15:0]      period_q;
    logic [IDX_W-1:0] pos;
    logic             match;
    logic [IDX_W-1:0] match_slot;
    logic             free;
    logic [IDX_W-1:0] free_slot;
    logic [CNT_W-1:0] n;
  } tok_t;

  // Dispatch event raised by a cell.
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] slot;
    logic [7:0]       task_id;
  } evt_t;

  // Write of a new task into one cell.
  typedef struct packed {
    logic [7:0]  task_id;
    logic [15:0] countdown;
    logic [15:0] period;
  } wr_t;

  // One result item.
  typedef struct packed {
    status_t    status;
    logic [2:0] slot;
    logic       run_valid;
    logic [7:0] run_task;
    logic       last;
  } res_t;

  // Milliseconds to ticks, truncated.
  function automatic logic [15:0] div_tick(input logic [15:0] x);
    logic [MULT_W-1:0] m;
    logic [PROD_W-1:0] p;
    m = MULT_W'(DIV_MULT);
    p = PROD_W'(x) * PROD_W'(m);
    return 16'(p >> DIV_SHIFT);
  endfunction

  // Slot index as reported, taken modulo 8.
  function automatic logic [2:0] to_slot(input logic [IDX_W-1:0] idx);
    logic [IDX_W+2:0] t;
    t = {3'b000, idx};
    return t[2:0];
  endfunction

endpackage

FILE: hw/rtl/pts_if.sv
// ----------------------------------------------------------------------------
// Periodic task tick scheduler channels
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface pts_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  task_id;
  logic [15:0] delay_ms;
  logic [15:0] period_ms;

  modport source (output valid, action, task_id, delay_ms, period_ms, input ready);
  modport sink   (input valid, action, task_id, delay_ms, period_ms, output ready);
endinterface

interface pts_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [2:0] slot;
  logic       run_valid;
  logic [7:0] run_task;
  logic       last;

  modport source (output valid, status, slot, run_valid, run_task, last, input ready);
  modport sink   (input valid, status, slot, run_valid, run_task, last, output ready);
endinterface

FILE: hw/rtl/periodic_task_tick_scheduler.sv
// ----------------------------------------------------------------------------
// Periodic task tick scheduler
// Cooperative time-triggered task table built as a chain of slot cells.
// ----------------------------------------------------------------------------
// Each command travels the chain of NUM_SLOTS slot cells one cell per cycle
// while the result register is not held by the downstream side, and its
// answer is registered once it leaves the last cell. The next item is taken
// once the previous one has left the chain, while its last result may still
// wait in the output register. Tick, add and delete give one result;
// dispatch gives one result per slot with pending runs, up to MAX_RESULTS,
// in slot order, or a single result with no run if no slot has one. Delays
// and periods are turned into ticks at the transfer. Reset empties the
// table at once; no clearing pass is needed.
module periodic_task_tick_scheduler
  import pts_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  pts_item_if.sink       item,
  pts_result_if.source   result
);

  tok_t             tok     [NUM_SLOTS+1];
  tok_t             tok_nxt [NUM_SLOTS];
  evt_t             evt     [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] wr_en;
  logic [NUM_SLOTS:0]   tok_vld;
  wr_t              wr;

  logic             busy;
  logic             stall;
  logic             accept;
  tok_t             fin;

  logic             any_hit;
  logic [IDX_W-1:0] hit_slot;
  logic [7:0]       hit_task;

  logic             hold_vld;
  logic [IDX_W-1:0] hold_slot;
  logic [7:0]       hold_task;

  logic             out_vld;
  res_t             res;
  logic             ld;
  res_t             res_next;
  logic             add_wr;

  // Handshake and chain control.
  always_comb begin
    for (int i = 0; i <= NUM_SLOTS; i++) tok_vld[i] = tok[i].vld;
  end
  assign busy       = |tok_vld;
  assign stall      = out_vld && !result.ready;
  assign item.ready = !busy;
  assign accept     = item.valid && item.ready;
  assign fin        = tok[NUM_SLOTS];

  // Chain of slot cells.
  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    pts_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (!stall),
      .tok_in  (tok[g]),
      .tok_out (tok_nxt[g]),
      .evt     (evt[g]),
      .wr_en   (wr_en[g]),
      .wr      (wr)
    );
  end

  // Token registers between the cells.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= NUM_SLOTS; i++) tok[i].vld <= 1'b0;
    end else begin
      if (accept) begin
        tok[0]            <= '0;
        tok[0].vld        <= 1'b1;
        tok[0].op         <= act_t'(item.action);
        tok[0].id         <= item.task_id;
        tok[0].delay_q    <= div_tick(item.delay_ms);
        tok[0].period_q   <= div_tick(item.period_ms);
      end else if (!stall) begin
        tok[0].vld <= 1'b0;
      end
      if (!stall) begin
        for (int i = 0; i < NUM_SLOTS; i++) tok[i+1] <= tok_nxt[i];
      end
    end
  end

  // At most one cell dispatches in a cycle, as only one token is in flight.
  always_comb begin
    any_hit  = 1'b0;
    hit_slot = '0;
    hit_task = 8'd0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (evt[i].hit) begin
        any_hit  = 1'b1;
        hit_slot = evt[i].slot;
        hit_task = evt[i].task_id;
      end
    end
  end

  // Write port for an accepted add.
  assign wr.task_id   = fin.id;
  assign wr.countdown = fin.delay_q;
  assign wr.period    = fin.period_q;
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      wr_en[i] = add_wr && (fin.free_slot == IDX_W'(i));
    end
  end

  // Result selection: a held dispatch result goes out when the next one is
  // found, and the final answer when the token leaves the chain.
  always_comb begin
    ld       = 1'b0;
    add_wr   = 1'b0;
    res_next = '0;
    res_next.status = ST_DONE;
    res_next.last   = 1'b1;
    if (!stall) begin
      if (any_hit) begin
        if (hold_vld) begin
          ld                 = 1'b1;
          res_next.slot      = to_slot(hold_slot);
          res_next.run_valid = 1'b1;
          res_next.run_task  = hold_task;
          res_next.last      = 1'b0;
        end
      end else if (fin.vld) begin
        ld = 1'b1;
        case (fin.op)
          ACT_TICK: begin
            res_next.status = ST_DONE;
          end
          ACT_ADD: begin
            if (fin.id == 8'd0) begin
              res_next.status = ST_BAD_ID;
            end else if (fin.match) begin
              res_next.status = ST_DUP;
              res_next.slot   = to_slot(fin.match_slot);
            end else if (!fin.free) begin
              res_next.status = ST_FULL;
            end else begin
              res_next.status = ST_ADDED;
              res_next.slot   = to_slot(fin.free_slot);
              add_wr          = 1'b1;
            end
          end
          ACT_DEL: begin
            if (fin.id == 8'd0) begin
              res_next.status = ST_BAD_ID;
            end else if (fin.match) begin
              res_next.status = ST_DELETED;
              res_next.slot   = to_slot(fin.match_slot);
            end else begin
              res_next.status = ST_NOTFOUND;
            end
          end
          ACT_DISP: begin
            if (hold_vld) begin
              res_next.slot      = to_slot(hold_slot);
              res_next.run_valid = 1'b1;
              res_next.run_task  = hold_task;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Hold register for the latest dispatch result.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_vld <= 1'b0;
    end else if (!stall) begin
      if (any_hit) begin
        hold_vld  <= 1'b1;
        hold_slot <= hit_slot;
        hold_task <= hit_task;
      end else if (fin.vld) begin
        hold_vld <= 1'b0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (ld) begin
      out_vld <= 1'b1;
      res     <= res_next;
    end else if (result.ready) begin
      out_vld <= 1'b0;
    end
  end

  assign result.valid     = out_vld;
  assign result.status    = res.status;
  assign result.slot      = res.slot;
  assign result.run_valid = res.run_valid;
  assign result.run_task  = res.run_task;
  assign result.last      = res.last;

  // A dispatch result is only held while its token is still in the chain.
  a_hold_busy: assert property (@(posedge clk) disable iff (rst)
    hold_vld |-> busy)
    else $error("dispatch result held with no token in flight");

  // Only one token travels the chain at a time.
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_vld))
    else $error("more than one token in the cell chain");

  // An accepted item enters the first cell.
  a_enter: assert property (@(posedge clk) disable iff (rst)
    accept |=> tok_vld[0])
    else $error("accepted item did not enter the chain");

  // A stalled output freezes the chain, though a new item may still enter.
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    (stall && !accept) |=> $stable(tok_vld))
    else $error("chain moved while the output was stalled");

  // A result that is not the last leaves a newer dispatch result held.
  a_not_last: assert property (@(posedge clk) disable iff (rst)
    (ld && !res_next.last) |=> hold_vld)
    else $error("intermediate result without a following one held");

endmodule

FILE: hw/rtl/pts_cell.sv
// ----------------------------------------------------------------------------
// Periodic task tick scheduler slot cell
// Holds one task slot, applies the passing token to it and hands the
// updated token on to the next cell.
// ----------------------------------------------------------------------------
module pts_cell
  import pts_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  tok_t tok_in,
  output tok_t tok_out,
  output evt_t evt,
  input  logic wr_en,
  input  wr_t  wr
);

  logic [7:0]  task_id;
  logic [15:0] countdown;
  logic [15:0] period;
  logic [7:0]  pending;

  logic [7:0]  task_next;
  logic [15:0] countdown_next;
  logic [15:0] period_next;
  logic [7:0]  pending_next;

  // Apply the token's operation to this slot.
  always_comb begin
    tok_out        = tok_in;
    tok_out.pos    = tok_in.pos + 1'b1;
    evt            = '0;
    task_next      = task_id;
    countdown_next = countdown;
    period_next    = period;
    pending_next   = pending;
    if (en && tok_in.vld) begin
      case (tok_in.op)
        ACT_TICK: begin
          if (task_id != 8'd0) begin
            if (countdown == 16'd0) begin
              if (pending != 8'hFF) pending_next = pending + 8'd1;
              if (period != 16'd0) countdown_next = period;
            end else begin
              countdown_next = countdown - 16'd1;
            end
          end
        end
        ACT_ADD: begin
          if (tok_in.id != 8'd0) begin
            if (task_id == tok_in.id && !tok_in.match) begin
              tok_out.match      = 1'b1;
              tok_out.match_slot = tok_in.pos;
            end
            if (task_id == 8'd0 && !tok_in.free) begin
              tok_out.free      = 1'b1;
              tok_out.free_slot = tok_in.pos;
            end
          end
        end
        ACT_DEL: begin
          if (tok_in.id != 8'd0 && task_id == tok_in.id && !tok_in.match) begin
            tok_out.match      = 1'b1;
            tok_out.match_slot = tok_in.pos;
            task_next          = 8'd0;
            countdown_next     = 16'd0;
            period_next        = 16'd0;
            pending_next       = 8'd0;
          end
        end
        ACT_DISP: begin
          if (task_id != 8'd0 && pending != 8'd0 && tok_in.n < CNT_W'(MAX_RESULTS)) begin
            evt.hit      = 1'b1;
            evt.slot     = tok_in.pos;
            evt.task_id  = task_id;
            tok_out.n    = tok_in.n + 1'b1;
            pending_next = pending - 8'd1;
            // A one-shot task leaves the table once dispatched.
            if (period == 16'd0) begin
              task_next      = 8'd0;
              countdown_next = 16'd0;
              pending_next   = 8'd0;
            end
          end
        end
        default: begin
        end
      endcase
    end
    // A new task is written once the add has found its free slot.
    if (en && wr_en) begin
      task_next      = wr.task_id;
      countdown_next = wr.countdown;
      period_next    = wr.period;
      pending_next   = 8'd0;
    end
  end

  // Slot registers, empty after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      task_id   <= 8'd0;
      countdown <= 16'd0;
      period    <= 16'd0;
      pending   <= 8'd0;
    end else begin
      task_id   <= task_next;
      countdown <= countdown_next;
      period    <= period_next;
      pending   <= pending_next;
    end
  end

endmodule
